[hdl/crc8_frame_deframer_assert.svh]
// assertion macros used by the deframer queue module
`ifndef CRC8_FRAME_DEFRAMER_ASSERT_SVH
`define CRC8_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication under reset
`define C8DF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define C8DF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/c8df_pkg.sv]
// shared types, constants and crc function of the frame deframer
package c8df_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = 5;
	localparam int ADDR_W      = IDX_W + 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int CNT_W       = 2;

	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic [1:0] REG_HOST   = 2'd0;
	localparam logic [1:0] REG_SLAVE  = 2'd1;
	localparam logic [1:0] REG_LAYOUT = 2'd2;

	localparam logic [1:0] LAYOUT_SEQ_FIRST  = 2'd0;
	localparam logic [1:0] LAYOUT_TYPE_FIRST = 2'd1;

	typedef enum logic [2:0] {
		ST_DST,
		ST_SRC,
		ST_HDR1,
		ST_HDR2,
		ST_LEN,
		ST_DATA,
		ST_CRC
	} parse_st_t;

	typedef struct packed {
		logic [7:0]       frame_type;
		logic [7:0]       seq_number;
		logic [LEN_W-1:0] payload_length;
		logic             bank;
	} frame_desc_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hdl/c8df_front.sv]
// front end: frame hunting, header capture, crc check and payload writes
module c8df_front import c8df_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        q_full,
	output logic        push,
	output frame_desc_t push_desc,
	output mem_wr_t     mem_wr
);

	parse_st_t state_q, state_nxt;

	logic [7:0]       host_q, slave_q;
	logic [1:0]       layout_q;
	logic [7:0]       seq_q, type_q, crc_q;
	logic [LEN_W-1:0] len_q, cnt_q;
	logic             bank_q;

	logic acc, active, host_hit, slave_hit, len_ok;
	logic [LEN_W-1:0] cnt_inc;
	logic crc_clr, crc_upd, ld_len, ld_first, ld_second, data_beat, crc_good;

	assign in_ready  = !q_full;
	assign acc       = in_valid && in_ready;
	assign active    = acc && (layout_q == LAYOUT_SEQ_FIRST || layout_q == LAYOUT_TYPE_FIRST);
	assign host_hit  = (rx_byte == host_q);
	assign slave_hit = (rx_byte == slave_q);
	assign len_ok    = ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD));
	assign cnt_inc   = cnt_q + LEN_W'(1);

	// next state
	always_comb begin
		state_nxt = state_q;
		if (active) begin
			case (state_q)
				ST_DST:  state_nxt = host_hit ? ST_SRC : ST_DST;
				ST_SRC:  state_nxt = slave_hit ? ST_HDR1 : (host_hit ? ST_SRC : ST_DST);
				ST_HDR1: state_nxt = ST_HDR2;
				ST_HDR2: state_nxt = ST_LEN;
				ST_LEN: begin
					if (len_ok) begin
						state_nxt = (rx_byte != 8'd0) ? ST_DATA : ST_CRC;
					end else begin
						state_nxt = host_hit ? ST_SRC : ST_DST;
					end
				end
				ST_DATA: state_nxt = (cnt_inc >= len_q) ? ST_CRC : ST_DATA;
				ST_CRC:  state_nxt = ST_DST;
				default: state_nxt = ST_DST;
			endcase
		end
	end

	// per-beat controls
	always_comb begin
		crc_clr   = 1'b0;
		crc_upd   = 1'b0;
		ld_len    = 1'b0;
		ld_first  = 1'b0;
		ld_second = 1'b0;
		data_beat = 1'b0;
		crc_good  = 1'b0;
		if (active) begin
			case (state_q)
				ST_DST:  crc_clr = host_hit;
				ST_SRC:  crc_clr = !slave_hit && host_hit;
				ST_HDR1: begin
					ld_first = 1'b1;
					crc_upd  = 1'b1;
				end
				ST_HDR2: begin
					ld_second = 1'b1;
					crc_upd   = 1'b1;
				end
				ST_LEN: begin
					ld_len  = len_ok;
					crc_upd = len_ok;
					crc_clr = !len_ok && host_hit;
				end
				ST_DATA: begin
					data_beat = 1'b1;
					crc_upd   = 1'b1;
				end
				ST_CRC:  crc_good = (rx_byte == crc_q);
				default: crc_clr = 1'b0;
			endcase
		end
	end

	assign push                     = crc_good;
	assign push_desc.frame_type     = type_q;
	assign push_desc.seq_number     = seq_q;
	assign push_desc.payload_length = len_q;
	assign push_desc.bank           = bank_q;
	assign mem_wr.en                = data_beat;
	assign mem_wr.addr              = {bank_q, cnt_q[IDX_W-1:0]};
	assign mem_wr.data              = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DST;
			host_q   <= '0;
			slave_q  <= '0;
			layout_q <= '0;
			seq_q    <= '0;
			type_q   <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			crc_q    <= '0;
			bank_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				case (cfg_index)
					REG_HOST:   host_q   <= cfg_data;
					REG_SLAVE:  slave_q  <= cfg_data;
					REG_LAYOUT: layout_q <= cfg_data[1:0];
					default:    host_q   <= host_q;
				endcase
			end
			if (crc_clr) begin
				crc_q <= '0;
			end else if (crc_upd) begin
				crc_q <= crc8_update(crc_q, rx_byte);
			end
			if ((ld_first && layout_q == LAYOUT_SEQ_FIRST) ||
			    (ld_second && layout_q == LAYOUT_TYPE_FIRST)) begin
				seq_q <= rx_byte;
			end
			if ((ld_first && layout_q == LAYOUT_TYPE_FIRST) ||
			    (ld_second && layout_q == LAYOUT_SEQ_FIRST)) begin
				type_q <= rx_byte;
			end
			if (ld_len) begin
				len_q <= rx_byte[LEN_W-1:0];
				cnt_q <= '0;
			end else if (data_beat) begin
				cnt_q <= cnt_inc;
			end
			if (crc_good) begin
				bank_q <= !bank_q;
			end
		end
	end

endmodule

[hdl/c8df_queue.sv]
// two-entry queue of good-frame descriptors between front and back
module c8df_queue import c8df_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	input  logic        pop,
	output logic        head_valid,
	output frame_desc_t head_desc,
	output logic        full
);

	`include "crc8_frame_deframer_assert.svh"

	frame_desc_t      entry_q [QUEUE_DEPTH];
	logic             wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`C8DF_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
	`C8DF_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "pop from empty queue")
	`C8DF_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
	`C8DF_ASSERT_NXT(a_push_shows, push && !pop, head_valid, "pushed frame not visible")

endmodule

[hdl/c8df_back.sv]
// back end: double-banked payload store and result read-out
module c8df_back import c8df_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_wr_t     mem_wr,
	input  logic        head_valid,
	input  frame_desc_t head_desc,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_type,
	output logic [7:0]  seq_number,
	output logic [LEN_W-1:0] payload_length,
	output logic [IDX_W-1:0] byte_index,
	output logic [7:0]  payload_byte,
	output logic        last_of_frame
);

	logic [7:0] store [2**ADDR_W];

	logic             out_valid_q, last_q, zero_q;
	logic [7:0]       type_q, seq_q, rd_data_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q, out_idx_q;
	logic             adv, load, is_last;

	assign adv     = !out_valid_q || out_ready;
	assign load    = adv && head_valid;
	assign is_last = (head_desc.payload_length == '0) ||
	                 ((LEN_W'(idx_q) + LEN_W'(1)) == head_desc.payload_length);
	assign pop     = load && is_last;

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			store[mem_wr.addr] <= mem_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rd_data_q <= store[{head_desc.bank, idx_q}];
			type_q    <= head_desc.frame_type;
			seq_q     <= head_desc.seq_number;
			len_q     <= head_desc.payload_length;
			zero_q    <= (head_desc.payload_length == '0);
			out_idx_q <= idx_q;
			last_q    <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_type     = type_q;
	assign seq_number     = seq_q;
	assign payload_length = len_q;
	assign byte_index     = out_idx_q;
	assign payload_byte   = zero_q ? 8'd0 : rd_data_q;
	assign last_of_frame  = last_q;

endmodule

[hdl/crc8_frame_deframer.sv]
// top level: crc-8 checked serial frame deframer
// takes one received byte per cycle; input stalls only while two good frames are still pending
// results pass the descriptor queue and output register; one per cycle while m_axis_tready is high
// read-out throughput is set by the single read port of the banked payload store
// reset clears parser state, registers and the descriptor queue; the store is not cleared
module crc8_frame_deframer import c8df_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // frame_type, seq_number, payload_length, byte_index, payload_byte
	output logic        m_axis_tlast,  // last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic             push, pop, head_valid, q_full;
	frame_desc_t      push_desc, head_desc;
	mem_wr_t          mem_wr;
	logic [7:0]       frame_type, seq_number, payload_byte;
	logic [LEN_W-1:0] payload_length;
	logic [IDX_W-1:0] byte_index;

	assign cfg_ready = 1'b1;

	c8df_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.rx_byte   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc),
		.mem_wr    (mem_wr)
	);

	c8df_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.full       (q_full)
	);

	c8df_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.mem_wr         (mem_wr),
		.head_valid     (head_valid),
		.head_desc      (head_desc),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.frame_type     (frame_type),
		.seq_number     (seq_number),
		.payload_length (payload_length),
		.byte_index     (byte_index),
		.payload_byte   (payload_byte),
		.last_of_frame  (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, payload_byte, byte_index, payload_length, seq_number, frame_type};

endmodule

[verif/crc8_frame_deframer_test.sv]
// testbench for the crc-8 frame deframer: random framed byte traffic checked against a parser model
module crc8_frame_deframer_test import c8df_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_UNUSED      = 2'd3;
	localparam logic [1:0] LAYOUT_OFF      = 2'd2;
	localparam logic [1:0] LAYOUT_OFF_ALT  = 2'd3;
	localparam int         SETTLE_CYCLES   = 8;
	localparam int         STALL_LIMIT     = 500;

	typedef logic [7:0] byte_q_t [$];

	typedef struct {
		logic [7:0]       frame_type;
		logic [7:0]       seq_number;
		logic [LEN_W-1:0] payload_length;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       payload_byte;
		logic             last_of_frame;
	} deframed_beat_t;

	typedef enum {
		SINK_FREE,
		SINK_COIN,
		SINK_TRICKLE,
		SINK_TWO_OF_THREE
	} sink_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;  // frame_type, seq_number, payload_length, byte_index, payload_byte
	logic        m_axis_tlast;  // last_of_frame
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_data = 8'h00;

	crc8_frame_deframer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// parser model state and register copies
	logic [7:0]       want_host = 8'h00;
	logic [7:0]       want_slave = 8'h00;
	logic [1:0]       want_layout = LAYOUT_SEQ_FIRST;
	parse_st_t        hunt_state = ST_DST;
	logic [7:0]       hunt_seq = 8'h00;
	logic [7:0]       hunt_type = 8'h00;
	logic [LEN_W-1:0] hunt_len = '0;
	logic [LEN_W-1:0] hunt_count = '0;
	logic [7:0]       hunt_crc = 8'h00;
	logic [7:0]       hunt_payload [MAX_PAYLOAD];

	byte_q_t          pending_bytes;
	deframed_beat_t   expected_beats [$];
	deframed_beat_t   head_beat;

	logic [7:0]       cur_host = 8'h00;
	logic [7:0]       cur_slave = 8'h00;
	int unsigned      bytes_queued = 0;
	int unsigned      bytes_taken = 0;
	int unsigned      frames_passed = 0;
	int unsigned      beats_checked = 0;
	int unsigned      errors = 0;
	int unsigned      idle_cycles = 0;

	int unsigned      burst_left = 1;
	int unsigned      gap_left = 0;
	sink_mode_t       sink_mode = SINK_FREE;
	int unsigned      sink_left = 0;
	int unsigned      sink_phase = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[0] ? ({1'b0, r[7:1]} ^ CRC_POLY) : {1'b0, r[7:1]};
		return r;
	endfunction

	task automatic keep_header(input logic [7:0] b, input bit first);
		if ((want_layout == LAYOUT_SEQ_FIRST) ? first : !first) begin
			hunt_seq = b;
		end else begin
			hunt_type = b;
		end
		hunt_crc = fold_crc(hunt_crc, b);
	endtask

	task automatic advance_parser(input logic [7:0] b);
		parse_st_t      st;
		int unsigned    cnt;
		deframed_beat_t beat;
		st = hunt_state;
		if (want_layout == LAYOUT_OFF || want_layout == LAYOUT_OFF_ALT) begin
			return;
		end
		if (st == ST_SRC) begin
			if (b == want_slave) begin
				hunt_state = ST_HDR1;
				return;
			end
			st = ST_DST;
		end else if (st == ST_LEN) begin
			if (b <= MAX_PAYLOAD) begin
				hunt_len = b[LEN_W-1:0];
				hunt_count = '0;
				hunt_crc = fold_crc(hunt_crc, b);
				hunt_state = (b != 8'd0) ? ST_DATA : ST_CRC;
				return;
			end
			st = ST_DST;
		end
		hunt_state = st;
		case (st)
			ST_DST: begin
				if (b == want_host) begin
					hunt_state = ST_SRC;
					hunt_crc = 8'h00;
				end
			end
			ST_HDR1: begin
				keep_header(b, 1'b1);
				hunt_state = ST_HDR2;
			end
			ST_HDR2: begin
				keep_header(b, 1'b0);
				hunt_state = ST_LEN;
			end
			ST_DATA: begin
				if (hunt_count < MAX_PAYLOAD) hunt_payload[hunt_count[IDX_W-1:0]] = b;
				hunt_count = hunt_count + 1'b1;
				hunt_crc = fold_crc(hunt_crc, b);
				if (hunt_count >= hunt_len) hunt_state = ST_CRC;
			end
			ST_CRC: begin
				hunt_state = ST_DST;
				if (b == hunt_crc) begin
					cnt = (hunt_len == 0) ? 1 : hunt_len;
					frames_passed++;
					for (int k = 0; k < cnt && k < MAX_PAYLOAD; k++) begin
						beat.frame_type     = hunt_type;
						beat.seq_number     = hunt_seq;
						beat.payload_length = hunt_len;
						beat.byte_index     = k[IDX_W-1:0];
						beat.payload_byte   = (hunt_len == 0) ? 8'h00 :
							hunt_payload[k[IDX_W-1:0]];
						beat.last_of_frame  = (k + 1 == cnt);
						expected_beats.push_back(beat);
					end
				end
			end
			default: hunt_state = ST_DST;
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// model update and result checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HOST:   want_host = cfg_data;
					REG_SLAVE:  want_slave = cfg_data;
					REG_LAYOUT: want_layout = cfg_data[1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_taken++;
				advance_parser(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with nothing expected: tdata 0x%0h tlast %0b",
						m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					head_beat = expected_beats.pop_front();
					check_field("frame_type", head_beat.frame_type, m_axis_tdata[7:0]);
					check_field("seq_number", head_beat.seq_number, m_axis_tdata[15:8]);
					check_field("payload_length", head_beat.payload_length, m_axis_tdata[21:16]);
					check_field("byte_index", head_beat.byte_index, m_axis_tdata[26:22]);
					check_field("payload_byte", head_beat.payload_byte, m_axis_tdata[34:27]);
					check_field("last_of_frame", head_beat.last_of_frame, m_axis_tlast);
					beats_checked++;
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// byte driver: bursts with random gaps
	always @(posedge clk) begin
		if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_bytes.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result sink back-pressure
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			sink_left <= $urandom_range(16, 80);
		end else begin
			sink_left <= sink_left - 1;
		end
		sink_phase <= sink_phase + 1;
		case (sink_mode)
			SINK_FREE:    m_axis_tready <= 1'b1;
			SINK_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
			SINK_TRICKLE: m_axis_tready <= (sink_phase % 8 == 0);
			default:      m_axis_tready <= (sink_phase % 3 != 0);
		endcase
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no beat for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_addresses(input logic [7:0] host, input logic [7:0] slave);
		cur_host = host;
		cur_slave = slave;
		write_reg(REG_HOST, host);
		write_reg(REG_SLAVE, slave);
	endtask

	task automatic set_layout(input logic [1:0] layout);
		logic [7:0] val;
		val = 8'($urandom);
		val[1:0] = layout;
		write_reg(REG_LAYOUT, val);
	endtask

	task automatic send_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic build_frame(input logic [7:0] dst, input logic [7:0] src,
		input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] len,
		input bit corrupt, output byte_q_t bytes);
		logic [7:0] crc;
		logic [7:0] d;
		bytes = {};
		bytes.push_back(dst);
		bytes.push_back(src);
		bytes.push_back(h1);
		bytes.push_back(h2);
		bytes.push_back(len);
		crc = fold_crc(fold_crc(fold_crc(8'h00, h1), h2), len);
		for (int i = 0; i < len; i++) begin
			d = 8'($urandom);
			bytes.push_back(d);
			crc = fold_crc(crc, d);
		end
		if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
		bytes.push_back(crc);
	endtask

	task automatic push_frame(input logic [7:0] h1, input logic [7:0] h2,
		input logic [7:0] len, input bit corrupt);
		byte_q_t bytes;
		build_frame(cur_host, cur_slave, h1, h2, len, corrupt, bytes);
		foreach (bytes[i]) send_byte(bytes[i]);
	endtask

	task automatic random_traffic(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		int unsigned len;
		start = bytes_queued;
		while (bytes_queued - start < budget) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 19) < 16) ? $urandom_range(0, 6) :
				($urandom_range(0, 3) != 0) ? $urandom_range(7, 31) : MAX_PAYLOAD;
			if (pick < 70) begin
				push_frame(8'($urandom), 8'($urandom), 8'(len), 1'b0);
			end else if (pick < 78) begin
				push_frame(8'($urandom), 8'($urandom), 8'(len), 1'b1);
			end else if (pick < 84) begin
				// wrong source, sometimes followed by a host byte
				send_byte(cur_host);
				send_byte(cur_slave ^ 8'($urandom_range(1, 255)));
				if ($urandom_range(0, 1)) send_byte(cur_host);
			end else if (pick < 89) begin
				send_byte(cur_host);
				send_byte(cur_slave);
				send_byte(8'($urandom));
				send_byte(8'($urandom));
				send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
			end else if (pick < 94) begin
				send_byte(cur_host);
				send_byte(cur_slave);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		while (!(pending_bytes.size() == 0 && !s_axis_tvalid && expected_beats.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		byte_q_t split_a;
		byte_q_t split_b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// host 0x21 doubles as an oversize length byte
		set_addresses(8'h21, 8'hC3);
		set_layout(LAYOUT_SEQ_FIRST);
		write_reg(REG_UNUSED, 8'($urandom));
		push_frame(8'h00, 8'hFF, 8'd0, 1'b0);
		send_byte(cur_host);
		push_frame(8'h5A, 8'hA5, 8'd2, 1'b0);
		send_byte(cur_host);
		send_byte(cur_slave);
		send_byte(8'h12);
		send_byte(8'h34);
		push_frame(8'hFF, 8'h00, 8'd0, 1'b0);
		push_frame(8'h77, 8'h88, 8'd0, 1'b1);
		wait_drained();

		set_addresses(8'hFF, 8'hFF);
		set_layout(LAYOUT_TYPE_FIRST);
		push_frame(8'($urandom), 8'($urandom), 8'(MAX_PAYLOAD), 1'b0);
		random_traffic(60);
		// leave a frame open after its first header byte
		build_frame(cur_host, cur_slave, 8'($urandom), 8'($urandom), 8'd3, 1'b0, split_a);
		for (int i = 0; i < 3; i++) send_byte(split_a[i]);
		wait_drained();

		set_addresses(8'($urandom), 8'($urandom));
		set_layout(LAYOUT_SEQ_FIRST);
		for (int i = 3; i < split_a.size(); i++) send_byte(split_a[i]);
		random_traffic(65);
		// leave a frame open just before its length byte
		build_frame(cur_host, cur_slave, 8'($urandom), 8'($urandom), 8'd4, 1'b0, split_b);
		for (int i = 0; i < 4; i++) send_byte(split_b[i]);
		wait_drained();

		set_layout(LAYOUT_OFF);
		repeat (20) send_byte(8'($urandom));
		wait_drained();

		set_layout(LAYOUT_OFF_ALT);
		repeat (15) send_byte(8'($urandom));
		wait_drained();

		set_addresses(8'h00, 8'h00);
		set_layout(LAYOUT_TYPE_FIRST);
		for (int i = 4; i < split_b.size(); i++) send_byte(split_b[i]);
		random_traffic(65);
		wait_drained();

		set_addresses(8'($urandom), 8'($urandom));
		set_layout(LAYOUT_SEQ_FIRST);
		random_traffic(65);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("%0d bytes sent, %0d frames passed crc, %0d result beats checked",
			bytes_taken, frames_passed, beats_checked);
		$display("both header orders, parser off, mid-frame layout change and dropped frames");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
